/* src/idll_pkg.sv */
`timescale 1ns / 1ps
package idll_pkg;
	localparam int Capacity = 256;
	localparam int SlotW = $clog2(Capacity);
	localparam int CountW = SlotW + 1;

	localparam logic [2:0] ActPushHead = 3'd0;
	localparam logic [2:0] ActPushTail = 3'd1;
	localparam logic [2:0] ActInsert   = 3'd2;
	localparam logic [2:0] ActPop      = 3'd3;
	localparam logic [2:0] ActRead     = 3'd4;

	localparam logic [1:0] StOk    = 2'd0;
	localparam logic [1:0] StEmpty = 2'd1;
	localparam logic [1:0] StRange = 2'd2;
	localparam logic [1:0] StFull  = 2'd3;

	localparam logic [2:0] MaxTag = 3'd6;
	localparam logic [2:0] VoidTagReset = 3'd5;

	typedef struct packed {
		logic [1:0]        status;
		logic [63:0]       out_payload;
		logic [2:0]        out_type;
		logic [CountW-1:0] entry_count;
	} result_t;

	typedef struct packed {
		logic [63:0]      payload;
		logic [2:0]       tag;
		logic [SlotW-1:0] next;
		logic [SlotW-1:0] prev;
	} slot_t;
endpackage

/* src/indexed_doubly_linked_list.sv */
`timescale 1ns / 1ps
// Ordered list engine over a 256-slot pool, one request at a time.
// Channels: s_axis_* carries requests, m_axis_* carries one result per
// request, cfg_* writes the void tag (values above 6 saturate to 6).
// A request is taken only when the engine is idle; the result sits in an
// output register until taken, and the next request is accepted while it
// waits, but its own result is held until the register frees.
// Indexed actions walk the links from the nearer end, one slot memory read
// per hop, at most 128 hops at full depth.
// The next request is accepted the cycle after the previous result is loaded.
// After reset the free stack memory is filled, one entry a cycle; no request
// is accepted during that sweep. The list starts empty and the void tag is 5.
// A stalled receiver holds the result; the engine waits before reporting.
module indexed_doubly_linked_list
	import idll_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] action, [11:3] position, [75:12] payload, [79:76] type_tag
	input  logic [79:0] s_axis_tdata,
	// [0] give_back
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [65:2] out_payload, [68:66] out_type, [77:69] entry_count
	output logic [79:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_POP_FREE, S_WALK, S_WALK_WAIT, S_GOT,
		S_NB_RD, S_NB_WAIT, S_NB_WR, S_NB2_RD, S_NB2_WAIT, S_NB2_WR, S_DONE
	} state_t;

	state_t            state_q;
	logic [SlotW-1:0]  init_q;
	logic [2:0]        void_q;
	logic [SlotW-1:0]  head_q, tail_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] idx_q;
	logic [CountW-1:0] hop_q;
	logic              back_q;
	logic [63:0]       pay_q;
	logic [2:0]        tag_q;
	logic              give_q;
	logic [SlotW-1:0]  cur_q;
	logic [SlotW-1:0]  new_q;
	logic [SlotW-1:0]  nx_q, pv_q;
	logic [1:0]        mode_q;
	result_t           res_q;
	logic              rvalid_q;
	result_t           pend_q;

	localparam logic [1:0] ModeNone = 2'd0;
	localparam logic [1:0] ModeIns  = 2'd1;
	localparam logic [1:0] ModeRem  = 2'd2;
	localparam logic [1:0] ModeRead = 2'd3;

	logic             s_we, f_we;
	logic [SlotW-1:0] s_waddr, s_raddr, f_waddr, f_wdata, f_raddr, f_rdata;
	slot_t            s_wdata, s_rdata;

	idll_slot_ram u_slot (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	idll_free_ram u_free (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	logic [2:0]        in_act;
	logic signed [8:0] in_pos;
	logic [3:0]        in_tag;
	logic [CountW-1:0] half;
	assign in_act = s_axis_tdata[2:0];
	assign in_pos = s_axis_tdata[11:3];
	assign in_tag = s_axis_tdata[79:76];
	assign half = count_q >> 1;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = rvalid_q;
	assign m_axis_tdata = {2'b00, res_q.entry_count, res_q.out_type,
		res_q.out_payload, res_q.status};

	always_comb begin
		s_we = 1'b0;
		s_waddr = cur_q;
		s_wdata = s_rdata;
		s_raddr = cur_q;
		f_we = 1'b0;
		f_waddr = init_q;
		f_wdata = init_q;
		f_raddr = SlotW'(Capacity - 1 - int'(count_q));
		unique case (state_q)
			S_INIT: f_we = 1'b1;
			S_GOT: begin
				if (mode_q == ModeIns) begin
					s_we = 1'b1;
					s_waddr = new_q;
					s_wdata.payload = pay_q;
					s_wdata.tag = tag_q;
					s_wdata.prev = cur_q;
					s_wdata.next = s_rdata.next;
					if (count_q == '0) begin
						s_wdata.prev = '0;
						s_wdata.next = '0;
					end else if (idx_q == '0) begin
						s_wdata.prev = '0;
						s_wdata.next = head_q;
					end else if (idx_q >= count_q) begin
						s_wdata.prev = tail_q;
						s_wdata.next = '0;
					end
				end else if (mode_q == ModeRem) begin
					f_we = 1'b1;
					f_waddr = SlotW'(Capacity - int'(count_q));
					f_wdata = cur_q;
				end
			end
			S_NB_RD, S_NB_WAIT: s_raddr = nx_q;
			S_NB_WR: begin
				s_we = 1'b1;
				s_waddr = nx_q;
				if (mode_q == ModeRem) s_wdata.prev = pv_q;
				else if (idx_q == '0) s_wdata.prev = new_q;
				else s_wdata.next = new_q;
			end
			S_NB2_RD, S_NB2_WAIT: s_raddr = pv_q;
			S_NB2_WR: begin
				s_we = 1'b1;
				s_waddr = pv_q;
				if (mode_q == ModeIns) s_wdata.prev = new_q;
				else s_wdata.next = nx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			void_q <= VoidTagReset;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			rvalid_q <= 1'b0;
			mode_q <= ModeNone;
		end else begin
			if (cfg_valid) void_q <= (cfg_data > MaxTag) ? MaxTag : cfg_data;
			if (rvalid_q && m_axis_tready) rvalid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == SlotW'(Capacity - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					pay_q <= s_axis_tdata[75:12];
					tag_q <= (in_tag > 4'(MaxTag)) ? void_q : in_tag[2:0];
					give_q <= s_axis_tuser;
					pend_q <= '0;
					pend_q.entry_count <= count_q;
					mode_q <= ModeNone;
					state_q <= S_DONE;
					if (in_act <= ActInsert) begin
						if (count_q >= CountW'(Capacity)) pend_q.status <= StFull;
						else if (in_act == ActInsert && in_pos < 0)
							pend_q.status <= StRange;
						else begin
							mode_q <= ModeIns;
							state_q <= S_POP_FREE;
							if (in_act == ActPushHead) idx_q <= '0;
							else if (in_act == ActPushTail
								|| CountW'(in_pos[7:0]) >= count_q)
								idx_q <= count_q;
							else idx_q <= CountW'(in_pos[7:0]);
						end
					end else if (in_act <= ActRead) begin
						if (count_q == '0) pend_q.status <= StEmpty;
						else if (in_act == ActPop && in_pos == -9'sd1) begin
							idx_q <= count_q - 1'b1;
							mode_q <= ModeRem;
							state_q <= S_POP_FREE;
						end else if (in_pos < 0 || CountW'(in_pos[7:0]) >= count_q)
							pend_q.status <= StRange;
						else begin
							idx_q <= CountW'(in_pos[7:0]);
							mode_q <= (in_act == ActPop) ? ModeRem : ModeRead;
							state_q <= S_POP_FREE;
						end
					end
				end
				S_POP_FREE: begin
					// free stack read issued this cycle; set up walk target
					new_q <= f_rdata;
					begin : setup
						logic [CountW-1:0] t;
						t = (mode_q == ModeIns) ? idx_q - 1'b1 : idx_q;
						if (mode_q == ModeIns && (count_q == '0 || idx_q == '0
							|| idx_q >= count_q)) begin
							hop_q <= '0;
							cur_q <= tail_q;
						end else if (t <= half) begin
							back_q <= 1'b0;
							cur_q <= head_q;
							hop_q <= t;
						end else begin
							back_q <= 1'b1;
							cur_q <= tail_q;
							hop_q <= count_q - 1'b1 - t;
						end
					end
					state_q <= S_WALK;
				end
				S_WALK: begin
					new_q <= f_rdata;
					state_q <= S_WALK_WAIT;
				end
				S_WALK_WAIT: state_q <= S_GOT;
				S_GOT: begin
					if (hop_q != '0) begin
						cur_q <= back_q ? s_rdata.prev : s_rdata.next;
						hop_q <= hop_q - 1'b1;
						state_q <= S_WALK_WAIT;
					end else begin
						nx_q <= s_rdata.next;
						pv_q <= s_rdata.prev;
						state_q <= S_DONE;
						if (mode_q == ModeRead) begin
							pend_q.out_payload <= s_rdata.payload;
							pend_q.out_type <= s_rdata.tag;
						end else if (mode_q == ModeIns) begin
							pend_q.entry_count <= count_q + 1'b1;
							count_q <= count_q + 1'b1;
							if (count_q == '0) begin
								head_q <= new_q;
								tail_q <= new_q;
							end else if (idx_q == '0) begin
								nx_q <= head_q;
								head_q <= new_q;
								state_q <= S_NB_RD;
							end else if (idx_q >= count_q) begin
								nx_q <= tail_q;
								tail_q <= new_q;
								state_q <= S_NB_RD;
							end else begin
								nx_q <= cur_q;
								pv_q <= s_rdata.next;
								state_q <= S_NB_RD;
							end
						end else begin
							pend_q.entry_count <= count_q - 1'b1;
							count_q <= count_q - 1'b1;
							if (give_q) begin
								pend_q.out_payload <= s_rdata.payload;
								pend_q.out_type <= s_rdata.tag;
							end
							if (idx_q == '0) head_q <= s_rdata.next;
							if (idx_q == count_q - 1'b1) tail_q <= s_rdata.prev;
							if (idx_q != count_q - 1'b1) state_q <= S_NB_RD;
							else if (idx_q != '0) state_q <= S_NB2_RD;
						end
					end
				end
				S_NB_RD: state_q <= S_NB_WAIT;
				S_NB_WAIT: state_q <= S_NB_WR;
				S_NB_WR: begin
					if (mode_q == ModeIns && idx_q != '0 && idx_q < count_q - 1'b1)
						state_q <= S_NB2_RD;
					else if (mode_q == ModeRem && idx_q != '0) state_q <= S_NB2_RD;
					else state_q <= S_DONE;
				end
				S_NB2_RD: state_q <= S_NB2_WAIT;
				S_NB2_WAIT: state_q <= S_NB2_WR;
				S_NB2_WR: state_q <= S_DONE;
				S_DONE: if (!rvalid_q || m_axis_tready) begin
					res_q <= pend_q;
					rvalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/idll_slot_ram.sv */
`timescale 1ns / 1ps
module idll_slot_ram
	import idll_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [SlotW-1:0] waddr,
	input  slot_t            wdata,
	input  logic [SlotW-1:0] raddr,
	output slot_t            rdata
);
	slot_t mem [Capacity];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/idll_free_ram.sv */
`timescale 1ns / 1ps
module idll_free_ram
	import idll_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [SlotW-1:0] waddr,
	input  logic [SlotW-1:0] wdata,
	input  logic [SlotW-1:0] raddr,
	output logic [SlotW-1:0] rdata
);
	logic [SlotW-1:0] mem [Capacity];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb
	import idll_pkg::*;
();

	localparam int MaxErrShown = 10;
	localparam int IdleLimit = 20000;
	localparam int RandItems = 1200;

	typedef struct {
		logic [2:0]  action;
		logic [8:0]  position;
		logic [63:0] payload;
		logic [3:0]  tag;
		logic        give_back;
		logic        has_exp;
		logic [1:0]  exp_status;
		logic [8:0]  exp_count;
	} row_t;

	typedef struct {
		logic [1:0]  status;
		logic [63:0] payload;
		logic [2:0]  otype;
		logic [8:0]  count;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;

	indexed_doubly_linked_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// list model: plain ordered array of entries
	logic [63:0] list_pay[$];
	logic [2:0]  list_tag[$];
	logic [2:0]  void_tag;
	res_t        pending[$];
	int          errors;
	int          idle_cycles;
	int          rx_stall;
	bit          rx_random;

	function automatic res_t predict_list_op(input logic [2:0] act, input logic [8:0] praw,
			input logic [63:0] pay, input logic [3:0] tag_in, input logic give);
		res_t r;
		int   pos;
		int   n;
		int   idx;
		logic [2:0] tg;
		r = '{default: '0};
		pos = $signed(praw);
		n = list_pay.size();
		tg = (tag_in > 4'd6) ? void_tag : tag_in[2:0];
		r.status = StOk;
		if (act == ActPushHead || act == ActPushTail || act == ActInsert) begin
			if (n >= Capacity) begin
				r.status = StFull;
			end else if (act == ActPushHead) begin
				list_pay.push_front(pay);
				list_tag.push_front(tg);
			end else if (act == ActPushTail) begin
				list_pay.push_back(pay);
				list_tag.push_back(tg);
			end else if (pos < 0) begin
				r.status = StRange;
			end else begin
				idx = (pos > n) ? n : pos;
				list_pay.insert(idx, pay);
				list_tag.insert(idx, tg);
			end
		end else if (act == ActPop || act == ActRead) begin
			if (n == 0) begin
				r.status = StEmpty;
			end else begin
				if (act == ActPop && pos == -1) idx = n - 1;
				else idx = pos;
				if (idx < 0 || idx >= n) begin
					r.status = StRange;
				end else begin
					if (act == ActRead || give) begin
						r.payload = list_pay[idx];
						r.otype = list_tag[idx];
					end
					if (act == ActPop) begin
						list_pay.delete(idx);
						list_tag.delete(idx);
					end
				end
			end
		end
		r.count = 9'(list_pay.size());
		return r;
	endfunction

	task automatic send_request(input row_t rw, input bit gaps);
		res_t r;
		int   g;
		if (gaps && $urandom_range(0, 3) == 0) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tdata <= {rw.tag, rw.payload, rw.position, rw.action};
		s_axis_tuser <= rw.give_back;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		r = predict_list_op(rw.action, rw.position, rw.payload, rw.tag, rw.give_back);
		if (rw.has_exp && (r.status != rw.exp_status || r.count != rw.exp_count)) begin
			errors++;
			if (errors <= MaxErrShown)
				$display("table row mismatch: predicted status %0d count %0d, table %0d %0d",
					r.status, r.count, rw.exp_status, rw.exp_count);
		end
		pending.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain_results;
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_void_tag(input logic [2:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		void_tag = (v > MaxTag) ? MaxTag : v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic row_t mk(input logic [2:0] a, input int p, input logic [63:0] d,
			input logic [3:0] t, input logic g);
		row_t rw;
		rw = '{default: '0};
		rw.action = a;
		rw.position = p[8:0];
		rw.payload = d;
		rw.tag = t;
		rw.give_back = g;
		return rw;
	endfunction

	function automatic row_t mke(input row_t rw, input logic [1:0] st, input int c);
		rw.has_exp = 1'b1;
		rw.exp_status = st;
		rw.exp_count = c[8:0];
		return rw;
	endfunction

	// result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[1:0];
			got.payload = m_axis_tdata[65:2];
			got.otype = m_axis_tdata[68:66];
			got.count = m_axis_tdata[77:69];
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MaxErrShown) $display("unexpected result %h", m_axis_tdata);
			end else begin
				want = pending.pop_front();
				if (got.status != want.status || got.payload != want.payload ||
						got.otype != want.otype || got.count != want.count) begin
					errors++;
					if (errors <= MaxErrShown)
						$display({"result mismatch: exp st %0d pay %h ty %0d n %0d,",
							" got st %0d pay %h ty %0d n %0d"},
							want.status, want.payload, want.otype, want.count,
							got.status, got.payload, got.otype, got.count);
				end
			end
		end
	end

	// output backpressure: mostly short stalls, now and then a long one
	always @(negedge clk) begin
		if (!rx_random) begin
			rx_stall = 0;
			m_axis_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
				: $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic row_t rand_row(input bit noise);
		row_t rw;
		int   n;
		int   a;
		rw = '{default: '0};
		n = list_pay.size();
		rw.payload = {$urandom, $urandom};
		rw.tag = 4'($urandom_range(0, 15));
		rw.give_back = 1'($urandom_range(0, 1));
		if (noise) begin
			rw.action = 3'($urandom_range(0, 7));
			rw.position = 9'($urandom_range(0, 511));
		end else begin
			a = $urandom_range(0, 99);
			// favour end pushes while short and indexed inserts when long; pop share stays the same
			if (n < 40 ? a < 45 : (n > 200 ? a < 20 : a < 35))
				rw.action = $urandom_range(0, 1) ? ActPushHead : ActPushTail;
			else if (a < 55) rw.action = ActInsert;
			else if (a < 78) rw.action = ActPop;
			else rw.action = ActRead;
			if (rw.action == ActPop && $urandom_range(0, 7) == 0)
				rw.position = 9'h1FF;
			else
				rw.position = 9'($urandom_range(0,
					(n > 0) ? n - 1 + (rw.action == ActInsert) : 0));
		end
		return rw;
	endfunction

	initial begin
		row_t rows[$];
		int   k;
		errors = 0;
		idle_cycles = 0;
		rx_random = 0;
		void_tag = VoidTagReset;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		rows.push_back(mke(mk(ActPop, -1, 0, 0, 1), StEmpty, 0));
		rows.push_back(mke(mk(ActRead, 0, 0, 0, 0), StEmpty, 0));
		rows.push_back(mke(mk(ActPushHead, 0, 64'h7FFF_FFFF_FFFF_FFFF, 4'd15, 0), StOk, 1));
		rows.push_back(mke(mk(ActPushTail, 0, 64'h8000_0000_0000_0000, 4'd6, 0), StOk, 2));
		rows.push_back(mke(mk(ActInsert, -1, 64'h1, 4'd0, 0), StRange, 2));
		rows.push_back(mke(mk(ActInsert, 0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1), StOk, 3));
		rows.push_back(mke(mk(ActInsert, 255, 64'h0, 4'd3, 0), StOk, 4));
		rows.push_back(mke(mk(ActInsert, 2, 64'hA5A5_5A5A_0F0F_F0F0, 4'd8, 0), StOk, 5));
		rows.push_back(mk(ActRead, 0, 0, 0, 0));
		rows.push_back(mk(ActRead, 4, 0, 0, 0));
		rows.push_back(mke(mk(ActRead, 5, 0, 0, 0), StRange, 5));
		rows.push_back(mke(mk(ActRead, -256, 0, 0, 0), StRange, 5));
		rows.push_back(mke(mk(ActPop, -2, 0, 0, 1), StRange, 5));
		rows.push_back(mke(mk(ActPop, 5, 0, 0, 1), StRange, 5));
		rows.push_back(mk(ActPop, -1, 0, 0, 1));
		rows.push_back(mk(ActPop, 0, 0, 0, 0));
		rows.push_back(mk(ActPop, 1, 0, 0, 1));
		rows.push_back(mke(mk(3'd5, 0, 64'h1234, 4'd1, 1), StOk, 2));
		rows.push_back(mke(mk(3'd7, -1, 0, 0, 0), StOk, 2));
		rows.push_back(mk(ActRead, 1, 0, 0, 0));
		foreach (rows[i]) send_request(rows[i], 0);
		drain_results();

		// saturating write, then fill to capacity
		write_void_tag(3'd7);
		for (k = 0; k < 254; k++) send_request(mk(ActPushTail, 0, {$urandom, $urandom}, 4'd15, 0), 0);
		send_request(mke(mk(ActPushHead, 0, 1, 4'd1, 0), StFull, 256), 0);
		send_request(mke(mk(ActInsert, 3, 1, 4'd1, 0), StFull, 256), 0);
		send_request(mk(ActRead, 255, 0, 0, 0), 0);
		send_request(mk(ActRead, 128, 0, 0, 0), 0);
		send_request(mk(ActPop, 200, 0, 0, 1), 0);
		send_request(mk(ActInsert, 130, 64'h55, 4'd9, 0), 0);
		drain_results();
		write_void_tag(3'd0);
		for (k = 0; k < 256; k++) send_request(mk(ActPop, $urandom_range(0, 255 - k), 0, 0, 1), 0);
		drain_results();

		rx_random = 1;
		for (k = 0; k < RandItems; k++) begin
			if (k % 400 == 399) begin
				drain_results();
				write_void_tag(3'($urandom_range(0, 7)));
			end
			send_request(rand_row($urandom_range(0, 9) == 0), 1);
		end
		rx_random = 0;
		drain_results();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
